/* design/midi_tep_pkg.sv */
package midi_tep_pkg;

  // parser phases
  typedef enum logic [3:0] {
    PH_DELTA  = 4'd0,
    PH_STATUS = 4'd1,
    PH_DATA1  = 4'd2,
    PH_DATA2  = 4'd3,
    PH_MCODE  = 4'd4,
    PH_MLEN   = 4'd5,
    PH_TEMPO  = 4'd6,
    PH_SXLEN  = 4'd7,
    PH_SKIP   = 4'd8
  } phase_e;

  // reported event kinds
  typedef enum logic [2:0] {
    KIND_CHANNEL    = 3'd0,
    KIND_SET_TEMPO  = 3'd1,
    KIND_OTHER_META = 3'd2,
    KIND_END_TRACK  = 3'd3,
    KIND_SYSEX      = 3'd4
  } event_kind_e;

  localparam logic [7:0] StatusMeta     = 8'hFF;
  localparam logic [7:0] StatusSysex    = 8'hF0;
  localparam logic [7:0] StatusSysexEsc = 8'hF7;
  localparam logic [7:0] MetaEndTrack   = 8'h2F;
  localparam logic [7:0] MetaSetTempo   = 8'h51;
  localparam logic [3:0] HiProgChange   = 4'hC;
  localparam logic [3:0] HiChanPress    = 4'hD;
  localparam logic [31:0] TempoLen      = 32'd3;

  // number of data bytes a channel status takes
  function automatic logic [1:0] params_for(input logic [7:0] st);
    params_for = (st[7:4] == HiProgChange || st[7:4] == HiChanPress) ? 2'd1 : 2'd2;
  endfunction

endpackage

/* design/midi_track_event_parser_unit.sv */
// channel | handshake              | payload
// in      | in_valid_i/in_stall_o  | data_byte_i, track_start_i
// out     | out_valid_o/out_stall_i| event_kind_o .. tempo_value_o
//
// one byte per cycle sustained unless out_stall_i holds a full result
// register; a byte is parsed while it sits in the input register and its
// event (if any) enters the result register once that register can advance.
// reset clears all parser state and leaves parsing stopped until a byte
// with track_start_i set arrives.
// out_stall_i holds the result register and, once the input register is
// also full, raises in_stall_o in the same cycle.
module midi_track_event_parser_unit
  import midi_tep_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        track_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_kind_o,
  output logic [31:0] delta_time_o,
  output logic [7:0]  status_byte_o,
  output logic [7:0]  data_one_o,
  output logic [7:0]  data_two_o,
  output logic [7:0]  meta_code_o,
  output logic [31:0] payload_length_o,
  output logic [23:0] tempo_value_o
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_data_q;
  logic       in_start_q;
  logic       advance;

  // parser state
  phase_e      phase_q, phase_d;
  logic [31:0] delta_q, delta_d;
  logic [7:0]  run_status_q, run_status_d;
  logic [7:0]  cur_status_q, cur_status_d;
  logic [7:0]  first_data_q, first_data_d;
  logic [1:0]  needed_q, needed_d;
  logic [7:0]  meta_code_q, meta_code_d;
  logic [31:0] len_q, len_d;
  logic [31:0] skip_q, skip_d;
  logic [23:0] tempo_q, tempo_d;
  logic        ended_q, ended_d;

  // event produced by this beat
  logic        ev_fire;
  event_kind_e ev_kind;
  logic [31:0] ev_delta;
  logic [7:0]  ev_status, ev_d1, ev_d2, ev_mcode;
  logic [31:0] ev_len;
  logic [23:0] ev_tempo;

  // result register
  logic        out_valid_q;
  event_kind_e out_kind_q;
  logic [31:0] out_delta_q;
  logic [7:0]  out_status_q, out_d1_q, out_d2_q, out_mcode_q;
  logic [31:0] out_len_q;
  logic [23:0] out_tempo_q;

  // handshake
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_data_q  <= data_byte_i;
      in_start_q <= track_start_i;
    end
  end

  // parse one byte
  always_comb begin
    logic [7:0]  b;
    logic        more;
    logic [31:0] skip_dec;
    b        = in_data_q;
    more     = b[7];
    skip_dec = 32'd0;

    phase_d      = phase_q;
    delta_d      = delta_q;
    run_status_d = run_status_q;
    cur_status_d = cur_status_q;
    first_data_d = first_data_q;
    needed_d     = needed_q;
    meta_code_d  = meta_code_q;
    len_d        = len_q;
    skip_d       = skip_q;
    tempo_d      = tempo_q;
    ended_d      = ended_q;

    ev_fire   = 1'b0;
    ev_kind   = KIND_CHANNEL;
    ev_delta  = 32'd0;
    ev_status = 8'd0;
    ev_d1     = 8'd0;
    ev_d2     = 8'd0;
    ev_mcode  = 8'd0;
    ev_len    = 32'd0;
    ev_tempo  = 24'd0;

    if (in_valid_q && advance) begin
      // new track clears everything, running status included
      if (in_start_q) begin
        phase_d      = PH_DELTA;
        delta_d      = 32'd0;
        run_status_d = 8'd0;
        cur_status_d = 8'd0;
        first_data_d = 8'd0;
        needed_d     = 2'd0;
        meta_code_d  = 8'd0;
        len_d        = 32'd0;
        skip_d       = 32'd0;
        tempo_d      = 24'd0;
        ended_d      = 1'b0;
      end

      if (!ended_d) begin
        unique case (phase_d)
          PH_DELTA: begin
            delta_d = {delta_d[24:0], b[6:0]};
            if (!more) phase_d = PH_STATUS;
          end
          PH_STATUS: begin
            if (b == StatusMeta) begin
              cur_status_d = b;
              phase_d      = PH_MCODE;
            end else if (b == StatusSysex || b == StatusSysexEsc) begin
              cur_status_d = b;
              len_d        = 32'd0;
              phase_d      = PH_SXLEN;
            end else if (more) begin
              cur_status_d = b;
              needed_d     = params_for(b);
              phase_d      = PH_DATA1;
            end else begin
              // running status: this byte is the first data byte
              cur_status_d = run_status_d;
              first_data_d = b;
              needed_d     = params_for(run_status_d);
              if (needed_d == 2'd1) begin
                run_status_d = cur_status_d;
                ev_fire      = 1'b1;
                ev_kind      = KIND_CHANNEL;
                ev_status    = cur_status_d;
                ev_d1        = b;
              end else begin
                phase_d = PH_DATA2;
              end
            end
          end
          PH_DATA1: begin
            first_data_d = b;
            if (needed_d == 2'd1) begin
              run_status_d = cur_status_d;
              ev_fire      = 1'b1;
              ev_kind      = KIND_CHANNEL;
              ev_status    = cur_status_d;
              ev_d1        = b;
            end else begin
              phase_d = PH_DATA2;
            end
          end
          PH_DATA2: begin
            run_status_d = cur_status_d;
            ev_fire      = 1'b1;
            ev_kind      = KIND_CHANNEL;
            ev_status    = cur_status_d;
            ev_d1        = first_data_d;
            ev_d2        = b;
          end
          PH_MCODE: begin
            meta_code_d = b;
            len_d       = 32'd0;
            phase_d     = PH_MLEN;
          end
          PH_MLEN: begin
            len_d = {len_d[24:0], b[6:0]};
            if (!more) begin
              if (meta_code_d == MetaEndTrack) begin
                ended_d   = 1'b1;
                ev_fire   = 1'b1;
                ev_kind   = KIND_END_TRACK;
                ev_status = StatusMeta;
                ev_mcode  = MetaEndTrack;
                ev_len    = len_d;
              end else if (meta_code_d == MetaSetTempo && len_d == TempoLen) begin
                tempo_d = 24'd0;
                skip_d  = TempoLen;
                phase_d = PH_TEMPO;
              end else if (len_d == 32'd0) begin
                ev_fire   = 1'b1;
                ev_kind   = KIND_OTHER_META;
                ev_status = StatusMeta;
                ev_mcode  = meta_code_d;
                ev_len    = len_d;
              end else begin
                skip_d  = len_d;
                phase_d = PH_SKIP;
              end
            end
          end
          PH_TEMPO: begin
            tempo_d = {tempo_d[15:0], b};
            skip_d  = skip_d - 32'd1;
            if (skip_d == 32'd0) begin
              ev_fire   = 1'b1;
              ev_kind   = KIND_SET_TEMPO;
              ev_status = StatusMeta;
              ev_mcode  = MetaSetTempo;
              ev_len    = TempoLen;
              ev_tempo  = tempo_d;
            end
          end
          PH_SXLEN: begin
            len_d = {len_d[24:0], b[6:0]};
            if (!more) begin
              if (len_d == 32'd0) begin
                ev_fire   = 1'b1;
                ev_kind   = KIND_SYSEX;
                ev_status = cur_status_d;
                ev_len    = len_d;
              end else begin
                skip_d  = len_d;
                phase_d = PH_SKIP;
              end
            end
          end
          PH_SKIP: begin
            if (skip_d != 32'd0) skip_dec = skip_d - 32'd1;
            skip_d = skip_dec;
            if (skip_dec == 32'd0) begin
              ev_fire = 1'b1;
              ev_len  = len_d;
              if (cur_status_d == StatusMeta) begin
                ev_kind   = KIND_OTHER_META;
                ev_status = StatusMeta;
                ev_mcode  = meta_code_d;
              end else begin
                ev_kind   = KIND_SYSEX;
                ev_status = cur_status_d;
              end
            end
          end
          default: begin
            phase_d = PH_DELTA;
          end
        endcase

        // an emitted event restarts the event scan
        if (ev_fire) begin
          ev_delta = delta_d;
          phase_d  = PH_DELTA;
          delta_d  = 32'd0;
          len_d    = 32'd0;
          tempo_d  = 24'd0;
          skip_d   = 32'd0;
        end
      end
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_DELTA;
      delta_q      <= 32'd0;
      run_status_q <= 8'd0;
      cur_status_q <= 8'd0;
      first_data_q <= 8'd0;
      needed_q     <= 2'd0;
      meta_code_q  <= 8'd0;
      len_q        <= 32'd0;
      skip_q       <= 32'd0;
      tempo_q      <= 24'd0;
      ended_q      <= 1'b1;
    end else begin
      phase_q      <= phase_d;
      delta_q      <= delta_d;
      run_status_q <= run_status_d;
      cur_status_q <= cur_status_d;
      first_data_q <= first_data_d;
      needed_q     <= needed_d;
      meta_code_q  <= meta_code_d;
      len_q        <= len_d;
      skip_q       <= skip_d;
      tempo_q      <= tempo_d;
      ended_q      <= ended_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= ev_fire;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (ev_fire) begin
      out_kind_q   <= ev_kind;
      out_delta_q  <= ev_delta;
      out_status_q <= ev_status;
      out_d1_q     <= ev_d1;
      out_d2_q     <= ev_d2;
      out_mcode_q  <= ev_mcode;
      out_len_q    <= ev_len;
      out_tempo_q  <= ev_tempo;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_kind_o     = out_kind_q;
  assign delta_time_o     = out_delta_q;
  assign status_byte_o    = out_status_q;
  assign data_one_o       = out_d1_q;
  assign data_two_o       = out_d2_q;
  assign meta_code_o      = out_mcode_q;
  assign payload_length_o = out_len_q;
  assign tempo_value_o    = out_tempo_q;

endmodule
